FILE: hw/rtl/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg
// Shared types, constants and helpers for the textured rectangle blitter.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int DST_MAX_W = 64;
    localparam int DST_MAX_H = 64;
    localparam int SRC_MAX_W = 64;
    localparam int SRC_MAX_H = 64;

    localparam int SZ_W   = 7;
    localparam int XY_W   = 6;
    localparam int ADDR_W = 12;
    localparam int PIX_W  = 32;
    localparam int CNT_W  = 13;
    localparam int CRD_W  = 9;
    localparam int DIF_W  = 10;
    localparam int SC_W   = 26;
    localparam int PRD_W  = 36;
    localparam int DVN_W  = 24;
    localparam int DVD_W  = 8;
    localparam int CFG_W  = 3;

    typedef enum logic [1:0] {
        KIND_WR_SRC,
        KIND_WR_DST,
        KIND_DRAW,
        KIND_READ
    } kind_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_DST_W,
        CFG_DST_H,
        CFG_SRC_W,
        CFG_SRC_H,
        CFG_SRC_EN
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_SCX,
        OP_SCY,
        OP_SX0,
        OP_DXI,
        OP_SY0,
        OP_DYI
    } div_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_COORD,
        S_CLIP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MULX,
        S_MULY,
        S_SPAN,
        S_PIX_RD,
        S_PIX_TINT,
        S_PIX_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    mem_write;
        logic    coord_en;
        logic    clip_en;
        logic    div_start;
        div_op_t div_op;
        logic    div_wb;
        logic    mul_en;
        logic    mul_y;
        logic    span_init;
        logic    pix_tint;
        logic    pix_wr;
        logic    res_load;
    } trb_cmd_t;

    typedef struct packed {
        logic reject;
        logic span_empty;
        logic div_done;
        logic last_pixel;
        logic out_free;
    } trb_stat_t;

    function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v,
                                                 input logic [SZ_W-1:0] mx);
        logic [SZ_W-1:0] r;
        if (v == '0)
            r = SZ_W'(1);
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

    // floor(v * (sz - 1) / 16384)
    function automatic logic signed [CRD_W-1:0] scale_crd(input logic signed [15:0] v,
                                                          input logic [SZ_W-1:0] sz);
        logic [7:0]         szm1;
        logic signed [23:0] p;
        szm1 = {1'b0, sz - 7'd1};
        p    = v * $signed(szm1);
        return p[22:14];
    endfunction

    // floor(p / 255) for p below 65280
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

endpackage

FILE: hw/rtl/trb_div.sv
// ----------------------------------------------------------------------------
// trb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trb_div
    import trb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVN_W-1:0] num,
    input  logic [DVD_W-1:0] den,
    output logic [DVN_W-1:0] quo,
    output logic [DVD_W-1:0] rem,
    output logic             done
);

    logic [DVN_W-1:0] q_reg, q_next;
    logic [DVD_W-1:0] r_reg, r_next;
    logic [DVD_W-1:0] d_reg;
    logic [4:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DVD_W:0]   trial;

    always_comb
    begin
        trial     = {r_reg, q_reg[DVN_W-1]};
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = num;
            r_next   = '0;
            cnt_next = 5'(DVN_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DVD_W'(trial - {1'b0, d_reg});
                q_next = {q_reg[DVN_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DVD_W-1:0];
                q_next = {q_reg[DVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
            d_reg <= den;
    end

    assign quo  = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/trb_dpath.sv
// ----------------------------------------------------------------------------
// trb_dpath
// Datapath: config registers, image stores, coordinate setup, divider
// operands, source stepping, tint and blend, result register.
// ----------------------------------------------------------------------------
module trb_dpath
    import trb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  trb_cmd_t                cmd,
    output trb_stat_t               stat,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_index,
    input  logic [SZ_W-1:0]         cfg_data,
    input  logic [1:0]              kind,
    input  logic signed [15:0]      dst_ax,
    input  logic signed [15:0]      dst_ay,
    input  logic signed [15:0]      dst_bx,
    input  logic signed [15:0]      dst_by,
    input  logic signed [15:0]      src_ax,
    input  logic signed [15:0]      src_ay,
    input  logic signed [15:0]      src_bx,
    input  logic signed [15:0]      src_by,
    input  logic [PIX_W-1:0]        color,
    input  logic [XY_W-1:0]         texel_x,
    input  logic [XY_W-1:0]         texel_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PIX_W-1:0]        read_data,
    output logic [CNT_W-1:0]        pixels_written,
    output logic                    rejected
);

    // configuration
    logic [SZ_W-1:0] dst_w_reg, dst_h_reg, src_w_reg, src_h_reg;
    logic            src_en_reg;
    logic [SZ_W-1:0] dw, dh, sw, sh;

    // captured transaction
    kind_t              kind_reg;
    logic signed [15:0] raw_reg [8];
    logic [PIX_W-1:0]   color_reg;
    logic [XY_W-1:0]    tx_reg, ty_reg;

    // draw setup
    logic signed [CRD_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [CRD_W-1:0] sax_reg, say_reg, sbx_reg, sby_reg;
    logic signed [CRD_W-1:0] minx, maxx, miny, maxy, dw_s, dh_s;
    logic [SZ_W-1:0]         minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic                    reject, rej_reg;
    logic signed [DIF_W-1:0] ddx, ddy, sdx, sdy;
    logic signed [SC_W-1:0]  scx_reg, scy_reg;
    logic signed [PRD_W-1:0] prodx_reg, prody_reg, prod;
    logic signed [DIF_W-1:0] mul_a;
    logic signed [SC_W-1:0]  mul_b;
    logic [XY_W-1:0]         sx0_reg, dxi_reg, dyi_reg;
    logic signed [20:0]      sxv, syv;

    // divider operands
    logic signed [SC_W-1:0] dv, dv_mag, qv, qs;
    logic [DVD_W-1:0]       dden;
    logic                   den_neg, den_zero;
    logic [DVN_W-1:0]       div_quo;
    logic [DVD_W-1:0]       div_rem;
    logic                   div_done;
    logic [SZ_W-1:0]        mmod, rr, wrapped;

    // sweep
    logic [XY_W-1:0]  x_reg, y_reg, sx_reg, sy_reg;
    logic [15:0]      fx_reg, fy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SZ_W-1:0]  x_inc, y_inc;
    logic [16:0]      fx_sum, fy_sum;
    logic [SZ_W-1:0]  sx_sum, sy_sum;

    // stores
    logic [PIX_W-1:0]  dst_mem [DST_MAX_W*DST_MAX_H];
    logic [PIX_W-1:0]  src_mem [SRC_MAX_W*SRC_MAX_H];
    logic [PIX_W-1:0]  dst_q_reg, src_q_reg, texel, blend, dst_wdata;
    logic [ADDR_W-1:0] dst_addr, src_addr;
    logic              dst_we, src_we;
    logic [7:0]        tint_reg [4];

    // result
    logic             out_valid_reg;
    logic [PIX_W-1:0] rd_out_reg;
    logic [CNT_W-1:0] pw_out_reg;
    logic             rj_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_w_reg  <= SZ_W'(DST_MAX_W);
            dst_h_reg  <= SZ_W'(DST_MAX_H);
            src_w_reg  <= SZ_W'(SRC_MAX_W);
            src_h_reg  <= SZ_W'(SRC_MAX_H);
            src_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DST_W:  dst_w_reg  <= cfg_data;
                CFG_DST_H:  dst_h_reg  <= cfg_data;
                CFG_SRC_W:  src_w_reg  <= cfg_data;
                CFG_SRC_H:  src_h_reg  <= cfg_data;
                CFG_SRC_EN: src_en_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign dw = eff_size(dst_w_reg, SZ_W'(DST_MAX_W));
    assign dh = eff_size(dst_h_reg, SZ_W'(DST_MAX_H));
    assign sw = src_en_reg ? eff_size(src_w_reg, SZ_W'(SRC_MAX_W)) : SZ_W'(1);
    assign sh = src_en_reg ? eff_size(src_h_reg, SZ_W'(SRC_MAX_H)) : SZ_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind_t'(kind);
            raw_reg[0] <= dst_ax;
            raw_reg[1] <= dst_ay;
            raw_reg[2] <= dst_bx;
            raw_reg[3] <= dst_by;
            raw_reg[4] <= src_ax;
            raw_reg[5] <= src_ay;
            raw_reg[6] <= src_bx;
            raw_reg[7] <= src_by;
            color_reg  <= color;
            tx_reg     <= texel_x;
            ty_reg     <= texel_y;
        end
        if (cmd.coord_en)
        begin
            dax_reg <= scale_crd(raw_reg[0], dw);
            day_reg <= scale_crd(raw_reg[1], dh);
            dbx_reg <= scale_crd(raw_reg[2], dw);
            dby_reg <= scale_crd(raw_reg[3], dh);
            sax_reg <= scale_crd(raw_reg[4], sw);
            say_reg <= scale_crd(raw_reg[5], sh);
            sbx_reg <= scale_crd(raw_reg[6], sw);
            sby_reg <= scale_crd(raw_reg[7], sh);
        end
    end

    // bounds, reject, clip
    always_comb
    begin
        minx   = (dax_reg < dbx_reg) ? dax_reg : dbx_reg;
        maxx   = (dax_reg < dbx_reg) ? dbx_reg : dax_reg;
        miny   = (day_reg < dby_reg) ? day_reg : dby_reg;
        maxy   = (day_reg < dby_reg) ? dby_reg : day_reg;
        dw_s   = $signed({2'b00, dw});
        dh_s   = $signed({2'b00, dh});
        reject = (minx >= dw_s) || (maxx < 9'sd0) || (miny >= dh_s) || (maxy < 9'sd0);
        ddx    = {dbx_reg[CRD_W-1], dbx_reg} - {dax_reg[CRD_W-1], dax_reg};
        ddy    = {dby_reg[CRD_W-1], dby_reg} - {day_reg[CRD_W-1], day_reg};
        sdx    = {sbx_reg[CRD_W-1], sbx_reg} - {sax_reg[CRD_W-1], sax_reg};
        sdy    = {sby_reg[CRD_W-1], sby_reg} - {say_reg[CRD_W-1], say_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip_en)
        begin
            minx_reg <= minx[CRD_W-1] ? '0 : minx[SZ_W-1:0];
            miny_reg <= miny[CRD_W-1] ? '0 : miny[SZ_W-1:0];
            maxx_reg <= (maxx > dw_s - 9'sd1) ? dw - 7'd1 : maxx[SZ_W-1:0];
            maxy_reg <= (maxy > dh_s - 9'sd1) ? dh - 7'd1 : maxy[SZ_W-1:0];
        end
    end

    // (start - corner) * scale
    always_comb
    begin
        if (cmd.mul_y)
        begin
            mul_a = $signed({3'b000, miny_reg}) - $signed({day_reg[CRD_W-1], day_reg});
            mul_b = scy_reg;
        end
        else
        begin
            mul_a = $signed({3'b000, minx_reg}) - $signed({dax_reg[CRD_W-1], dax_reg});
            mul_b = scx_reg;
        end
        prod = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en && !cmd.mul_y)
            prodx_reg <= prod;
        if (cmd.mul_en && cmd.mul_y)
            prody_reg <= prod;
    end

    assign sxv = {prodx_reg[PRD_W-1], prodx_reg[PRD_W-1:16]}
               + {{12{sax_reg[CRD_W-1]}}, sax_reg};
    assign syv = {prody_reg[PRD_W-1], prody_reg[PRD_W-1:16]}
               + {{12{say_reg[CRD_W-1]}}, say_reg};

    // divider operand select
    always_comb
    begin
        dv      = '0;
        den_neg = 1'b0;
        dden    = '0;
        mmod    = sw;
        case (cmd.div_op)
            OP_SCX:
            begin
                dv      = {sdx, 16'd0};
                den_neg = ddx[DIF_W-1];
                dden    = den_neg ? DVD_W'(-ddx) : ddx[DVD_W-1:0];
            end
            OP_SCY:
            begin
                dv      = {sdy, 16'd0};
                den_neg = ddy[DIF_W-1];
                dden    = den_neg ? DVD_W'(-ddy) : ddy[DVD_W-1:0];
            end
            OP_SX0:
            begin
                dv   = {{5{sxv[20]}}, sxv};
                mmod = sw;
            end
            OP_DXI:
            begin
                dv   = {{16{scx_reg[SC_W-1]}}, scx_reg[SC_W-1:16]};
                mmod = sw;
            end
            OP_SY0:
            begin
                dv   = {{5{syv[20]}}, syv};
                mmod = sh;
            end
            OP_DYI:
            begin
                dv   = {{16{scy_reg[SC_W-1]}}, scy_reg[SC_W-1:16]};
                mmod = sh;
            end
            default: ;
        endcase
        if (cmd.div_op == OP_SX0 || cmd.div_op == OP_DXI ||
            cmd.div_op == OP_SY0 || cmd.div_op == OP_DYI)
            dden = {1'b0, mmod};
        dv_mag   = dv[SC_W-1] ? -dv : dv;
        den_zero = (dden == '0);
        qv       = {2'b00, div_quo};
        qs       = (dv[SC_W-1] ^ den_neg) ? -qv : qv;
        rr       = div_rem[SZ_W-1:0];
        wrapped  = (dv[SC_W-1] && rr != '0) ? mmod - rr : rr;
    end

    trb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dv_mag[DVN_W-1:0]),
        .den   (dden),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    // sweep stepping
    always_comb
    begin
        x_inc  = {1'b0, x_reg} + 7'd1;
        y_inc  = {1'b0, y_reg} + 7'd1;
        fx_sum = {1'b0, fx_reg} + {1'b0, scx_reg[15:0]};
        fy_sum = {1'b0, fy_reg} + {1'b0, scy_reg[15:0]};
        sx_sum = {1'b0, sx_reg} + {1'b0, dxi_reg} + {6'd0, fx_sum[16]};
        sy_sum = {1'b0, sy_reg} + {1'b0, dyi_reg} + {6'd0, fy_sum[16]};
        if (sx_sum >= sw)
            sx_sum = sx_sum - sw;
        if (sy_sum >= sh)
            sy_sum = sy_sum - sh;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_wb)
        begin
            case (cmd.div_op)
                OP_SCX:  scx_reg <= den_zero ? '0 : qs;
                OP_SCY:  scy_reg <= den_zero ? '0 : qs;
                OP_SX0:  sx0_reg <= wrapped[XY_W-1:0];
                OP_DXI:  dxi_reg <= wrapped[XY_W-1:0];
                OP_SY0:  sy_reg  <= wrapped[XY_W-1:0];
                OP_DYI:  dyi_reg <= wrapped[XY_W-1:0];
                default: ;
            endcase
        end
        if (cmd.span_init)
        begin
            x_reg  <= minx_reg[XY_W-1:0];
            y_reg  <= miny_reg[XY_W-1:0];
            sx_reg <= sx0_reg;
            fx_reg <= prodx_reg[15:0];
            fy_reg <= prody_reg[15:0];
        end
        else if (cmd.pix_wr)
        begin
            if (x_inc < maxx_reg)
            begin
                x_reg  <= x_inc[XY_W-1:0];
                fx_reg <= fx_sum[15:0];
                sx_reg <= sx_sum[XY_W-1:0];
            end
            else
            begin
                x_reg  <= minx_reg[XY_W-1:0];
                fx_reg <= prodx_reg[15:0];
                sx_reg <= sx0_reg;
                y_reg  <= y_inc[XY_W-1:0];
                fy_reg <= fy_sum[15:0];
                sy_reg <= sy_sum[XY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rej_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
            rej_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clip_en)
                rej_reg <= reject;
            if (cmd.pix_wr)
                cnt_reg <= cnt_reg + 13'd1;
        end
    end

    // stores
    assign dst_addr = (kind_reg == KIND_DRAW) ? {y_reg, x_reg} : {ty_reg, tx_reg};
    assign src_addr = (kind_reg == KIND_DRAW) ? {sy_reg, sx_reg} : {ty_reg, tx_reg};
    assign dst_we   = (cmd.mem_write && kind_reg == KIND_WR_DST) || cmd.pix_wr;
    assign src_we   = cmd.mem_write && kind_reg == KIND_WR_SRC;
    assign dst_wdata = cmd.pix_wr ? blend : color_reg;

    always_ff @(posedge clk)
    begin
        if (dst_we)
            dst_mem[dst_addr] <= dst_wdata;
        dst_q_reg <= dst_mem[dst_addr];
    end

    always_ff @(posedge clk)
    begin
        if (src_we)
            src_mem[src_addr] <= color_reg;
        src_q_reg <= src_mem[src_addr];
    end

    // tint then blend
    assign texel = src_en_reg ? src_q_reg : '1;

    always_ff @(posedge clk)
    begin
        if (cmd.pix_tint)
        begin
            for (int i = 0; i < 4; i++)
                tint_reg[i] <= div255({8'd0, texel[8*i +: 8]} * {8'd0, color_reg[8*i +: 8]});
        end
    end

    always_comb
    begin
        logic [17:0] ea;
        logic [17:0] c;
        blend = '0;
        ea    = {10'd0, tint_reg[3]};
        for (int i = 0; i < 4; i++)
        begin
            c = (ea + 18'd1) * {10'd0, tint_reg[i]}
              + (18'd256 - ea) * {10'd0, dst_q_reg[8*i +: 8]};
            blend[8*i +: 8] = c[15:8];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            rd_out_reg <= (kind_reg == KIND_READ) ? dst_q_reg : '0;
            pw_out_reg <= cnt_reg;
            rj_out_reg <= rej_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = rd_out_reg;
    assign pixels_written = pw_out_reg;
    assign rejected       = rj_out_reg;

    assign stat.reject     = reject;
    assign stat.span_empty = (minx_reg >= maxx_reg) || (miny_reg >= maxy_reg);
    assign stat.div_done   = div_done;
    assign stat.last_pixel = (x_inc == maxx_reg) && (y_inc == maxy_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

FILE: hw/rtl/trb_ctrl.sv
// ----------------------------------------------------------------------------
// trb_ctrl
// Sequencer: transaction decode, draw setup, divider schedule, pixel sweep.
// ----------------------------------------------------------------------------
module trb_ctrl
    import trb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] kind,
    input  trb_stat_t stat,
    output trb_cmd_t  cmd
);

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SCX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.div_op = op_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (kind_t'(kind))
                        KIND_WR_SRC,
                        KIND_WR_DST: state_next = S_WRITE;
                        KIND_DRAW:   state_next = S_COORD;
                        KIND_READ:   state_next = S_READ;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.mem_write = 1'b1;
                state_next    = S_DONE;
            end
            S_READ:
                state_next = S_DONE;
            S_COORD:
            begin
                cmd.coord_en = 1'b1;
                state_next   = S_CLIP;
            end
            S_CLIP:
            begin
                cmd.clip_en = 1'b1;
                op_next     = OP_SCX;
                state_next  = stat.reject ? S_DONE : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_wb = 1'b1;
                    case (op_reg)
                        OP_SCX:
                        begin
                            op_next    = OP_SCY;
                            state_next = S_DIV_GO;
                        end
                        OP_SCY:  state_next = S_MULX;
                        OP_SX0:
                        begin
                            op_next    = OP_DXI;
                            state_next = S_DIV_GO;
                        end
                        OP_DXI:
                        begin
                            op_next    = OP_SY0;
                            state_next = S_DIV_GO;
                        end
                        OP_SY0:
                        begin
                            op_next    = OP_DYI;
                            state_next = S_DIV_GO;
                        end
                        default: state_next = S_SPAN;
                    endcase
                end
            end
            S_MULX:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_y  = 1'b1;
                op_next    = OP_SX0;
                state_next = S_DIV_GO;
            end
            S_SPAN:
            begin
                cmd.span_init = 1'b1;
                state_next    = stat.span_empty ? S_DONE : S_PIX_RD;
            end
            S_PIX_RD:
                state_next = S_PIX_TINT;
            S_PIX_TINT:
            begin
                cmd.pix_tint = 1'b1;
                state_next   = S_PIX_WR;
            end
            S_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                state_next = stat.last_pixel ? S_DONE : S_PIX_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/textured_rect_blit_alpha_blend.sv
// ----------------------------------------------------------------------------
// textured_rect_blit_alpha_blend
// Scaled, tinted texture rectangle blitter with alpha blending into a
// 64x64 RGBA destination.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  kind, corners, color, texel_x/y
//   out      source     out_valid/out_ready  read_data, pixels_written, rejected
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Writes and reads go through S_WRITE or S_READ, then S_DONE. A draw runs setup
// and six divider passes, then one read-modify-write of the destination store per
// blended pixel; a rejected draw goes from S_CLIP to S_DONE. One transaction in
// flight; the next is taken while a result waits in the output register. Reset
// is asynchronous; the image stores are not cleared.
// ----------------------------------------------------------------------------
module textured_rect_blit_alpha_blend
    import trb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic signed [15:0]  dst_ax,
    input  logic signed [15:0]  dst_ay,
    input  logic signed [15:0]  dst_bx,
    input  logic signed [15:0]  dst_by,
    input  logic signed [15:0]  src_ax,
    input  logic signed [15:0]  src_ay,
    input  logic signed [15:0]  src_bx,
    input  logic signed [15:0]  src_by,
    input  logic [PIX_W-1:0]    color,
    input  logic [XY_W-1:0]     texel_x,
    input  logic [XY_W-1:0]     texel_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PIX_W-1:0]    read_data,
    output logic [CNT_W-1:0]    pixels_written,
    output logic                rejected,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_index,
    input  logic [SZ_W-1:0]     cfg_data
);

    trb_cmd_t  cmd;
    trb_stat_t stat;

    assign cfg_ready = 1'b1;

    trb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .stat     (stat),
        .cmd      (cmd)
    );

    trb_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .dst_ax         (dst_ax),
        .dst_ay         (dst_ay),
        .dst_bx         (dst_bx),
        .dst_by         (dst_by),
        .src_ax         (src_ax),
        .src_ay         (src_ay),
        .src_bx         (src_bx),
        .src_by         (src_by),
        .color          (color),
        .texel_x        (texel_x),
        .texel_y        (texel_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .pixels_written (pixels_written),
        .rejected       (rejected)
    );

endmodule

FILE: hw/rtl/trb_checker.sv
// ----------------------------------------------------------------------------
// trb_checker
// Port-level checks for the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module trb_checker
    import trb_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] read_data,
    input logic [CNT_W-1:0] pixels_written,
    input logic             rejected
);

    // held result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(pixels_written) && $stable(rejected))
        else $error("result changed while stalled");

    // one transaction at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> read_data == '0 && pixels_written == '0)
        else $error("rejected draw carries data");

    a_draw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixels_written != '0 |-> read_data == '0)
        else $error("draw result carries read data");

endmodule

bind textured_rect_blit_alpha_blend trb_checker u_chk (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for textured_rect_blit_alpha_blend. A small corner of
// both image stores is preloaded; the size registers keep every draw inside
// it and reads use it or entries written first, so no unwritten entry is
// touched. A short directed table runs, then random transactions over several
// register settings. Results are checked against table rows or a predictor.
// ----------------------------------------------------------------------------
module tb;
    import trb_pkg::*;

    localparam int FILL_N = 6;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] dax, day, dbx, dby, sax, say, sbx, sby;
        logic [31:0]        color;
        logic [5:0]         tx, ty;
    } blit_txn_t;

    typedef struct packed {
        logic [31:0] rd;
        logic [12:0] pw;
        logic        rj;
    } blit_res_t;

    typedef struct packed {
        blit_txn_t txn;
        logic      typed;
        blit_res_t res;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    blit_txn_t cur = '0;
    logic cur_typed = 1'b0;
    blit_res_t cur_res = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] read_data;
    logic [12:0] pixels_written;
    logic rejected;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_idx_t cfg_index = CFG_DST_W;
    logic [6:0] cfg_data = '0;

    logic [31:0] dst_mem [4096];
    logic [31:0] src_mem [4096];
    int unsigned reg_dw = 64, reg_dh = 64, reg_sw = 64, reg_sh = 64, reg_en = 0;
    blit_res_t pending_results[$];
    int mismatches = 0;
    bit sender_gaps = 1'b0;
    bit receiver_gaps = 1'b0;
    table_row_t rows[$];

    textured_rect_blit_alpha_blend dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(cur.kind),
        .dst_ax(cur.dax), .dst_ay(cur.day), .dst_bx(cur.dbx), .dst_by(cur.dby),
        .src_ax(cur.sax), .src_ay(cur.say), .src_bx(cur.sbx), .src_by(cur.sby),
        .color(cur.color), .texel_x(cur.tx), .texel_y(cur.ty),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_data(read_data), .pixels_written(pixels_written), .rejected(rejected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("[textured_rect_blit_alpha_blend] ERROR");
        $finish;
    end

    function automatic longint floor_q(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint clamp_size(int unsigned v, int unsigned mx);
        if (v == 0)
            return 1;
        if (v > mx)
            return mx;
        return v;
    endfunction

    function automatic longint norm_to_px(logic signed [15:0] v, longint sz);
        return floor_q(longint'(v) * (sz - 1), 16384);
    endfunction

    function automatic longint wrap_px(longint a, longint m);
        longint r;
        r = a % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    function automatic logic [31:0] tint_blend(logic [31:0] texel, logic [31:0] tint,
                                               logic [31:0] under);
        int unsigned ch[4];
        int unsigned c;
        logic [31:0] res;
        res = '0;
        for (int i = 0; i < 4; i++)
            ch[i] = (int'(texel[8*i +: 8]) * int'(tint[8*i +: 8])) / 255;
        for (int i = 0; i < 4; i++)
        begin
            c = ((ch[3] + 1) * ch[i] + (256 - ch[3]) * int'(under[8*i +: 8])) >> 8;
            res[8*i +: 8] = c[7:0];
        end
        return res;
    endfunction

    // applies one transaction to the image mirror and returns its result
    function automatic blit_res_t blit_apply(blit_txn_t t);
        blit_res_t r;
        longint dw, dh, sw, sh, ax, ay, bx, by, sax, say, sbx, sby;
        longint x0, x1, y0, y1, scx, scy, sx, sy;
        int unsigned n;
        logic [31:0] texel;
        r = '0;
        n = 0;
        case (t.kind)
            KIND_WR_SRC: src_mem[{t.ty, t.tx}] = t.color;
            KIND_WR_DST: dst_mem[{t.ty, t.tx}] = t.color;
            KIND_READ:   r.rd = dst_mem[{t.ty, t.tx}];
            default:
            begin
                dw = clamp_size(reg_dw, DST_MAX_W);
                dh = clamp_size(reg_dh, DST_MAX_H);
                sw = reg_en ? clamp_size(reg_sw, SRC_MAX_W) : 1;
                sh = reg_en ? clamp_size(reg_sh, SRC_MAX_H) : 1;
                ax = norm_to_px(t.dax, dw);  ay = norm_to_px(t.day, dh);
                bx = norm_to_px(t.dbx, dw);  by = norm_to_px(t.dby, dh);
                sax = norm_to_px(t.sax, sw); say = norm_to_px(t.say, sh);
                sbx = norm_to_px(t.sbx, sw); sby = norm_to_px(t.sby, sh);
                x0 = ax < bx ? ax : bx;  x1 = ax < bx ? bx : ax;
                y0 = ay < by ? ay : by;  y1 = ay < by ? by : ay;
                if (x0 >= dw || x1 < 0 || y0 >= dh || y1 < 0)
                    r.rj = 1'b1;
                else
                begin
                    if (x0 < 0) x0 = 0;
                    if (y0 < 0) y0 = 0;
                    if (x1 > dw - 1) x1 = dw - 1;
                    if (y1 > dh - 1) y1 = dh - 1;
                    scx = (bx != ax) ? ((sbx - sax) * 65536) / (bx - ax) : 0;
                    scy = (by != ay) ? ((sby - say) * 65536) / (by - ay) : 0;
                    for (longint y = y0; y < y1; y++)
                    begin
                        sy = wrap_px(say + floor_q((y - ay) * scy, 65536), sh);
                        for (longint x = x0; x < x1; x++)
                        begin
                            sx = wrap_px(sax + floor_q((x - ax) * scx, 65536), sw);
                            texel = reg_en ? src_mem[sy * 64 + sx] : 32'hFFFF_FFFF;
                            dst_mem[y * 64 + x] = tint_blend(texel, t.color,
                                                             dst_mem[y * 64 + x]);
                            n++;
                        end
                    end
                    r.pw = n[12:0];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        blit_res_t want;
        blit_res_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{read_data, pixels_written, rejected};
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result rd=%h pw=%0d rj=%b",
                                 got.rd, got.pw, got.rj);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp rd=%h pw=%0d rj=%b, got rd=%h pw=%0d rj=%b",
                                     want.rd, want.pw, want.rj, got.rd, got.pw, got.rj);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = blit_apply(cur);
                pending_results.push_back(cur_typed ? cur_res : want);
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_DST_W:  reg_dw = cfg_data;
                    CFG_DST_H:  reg_dh = cfg_data;
                    CFG_SRC_W:  reg_sw = cfg_data;
                    CFG_SRC_H:  reg_sh = cfg_data;
                    CFG_SRC_EN: reg_en = cfg_data[0];
                    default: ;
                endcase
        end
    end

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        int hold;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (!receiver_gaps)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 5) == 0)
        begin
            hold = $urandom_range(1, 15);
            out_ready <= 1'b0;
            repeat (hold) @(posedge clk);
            out_ready <= 1'b1;
        end
        else
            out_ready <= 1'b1;
    end

    // valid stays high between back-to-back transactions unless a random gap is inserted
    task automatic send(blit_txn_t t, logic typed, blit_res_t r);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cur <= t;
        cur_typed <= typed;
        cur_res <= r;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[6:0];
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    function automatic logic signed [15:0] rand_corner();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 16384));
            2:       return -16'sd32768 + 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 20000)) - 16'sd2000;
        endcase
    endfunction

    function automatic blit_txn_t rand_txn();
        blit_txn_t t;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        t.kind = pick < 4 ? KIND_DRAW : pick < 6 ? KIND_READ
               : pick < 8 ? KIND_WR_DST : KIND_WR_SRC;
        t.dax = rand_corner(); t.day = rand_corner();
        t.dbx = rand_corner(); t.dby = rand_corner();
        t.sax = rand_corner(); t.say = rand_corner();
        t.sbx = rand_corner(); t.sby = rand_corner();
        t.color = $urandom;
        t.tx = 6'($urandom);
        t.ty = 6'($urandom);
        if (t.kind == KIND_READ)
        begin
            t.tx = 6'($urandom_range(0, FILL_N - 1));
            t.ty = 6'($urandom_range(0, FILL_N - 1));
        end
        return t;
    endfunction

    function automatic table_row_t row(kind_t k, int ax, int ay, int bx, int by,
                                       int sax, int say, int sbx, int sby,
                                       logic [31:0] c, int x, int y,
                                       logic typed, logic [31:0] rd, int pw, logic rj);
        table_row_t r;
        r.txn = '{k, 16'(ax), 16'(ay), 16'(bx), 16'(by), 16'(sax), 16'(say),
                  16'(sbx), 16'(sby), c, 6'(x), 6'(y)};
        r.typed = typed;
        r.res = '{rd, 13'(pw), rj};
        return r;
    endfunction

    initial
    begin
        blit_txn_t t;
        int unsigned phase_regs[6][5];
        int phase_items[6];

        // sizes keep draws inside the preloaded corner
        phase_regs = '{
            '{0, 1, 0, 6, 1},
            '{5, 7, 3, 6, 1},
            '{7, 7, 6, 6, 1},
            '{7, 6, 127, 0, 0},
            '{3, 3, 6, 5, 1},
            '{6, 6, 4, 4, 1}
        };
        phase_items = '{8, 10, 10, 8, 9, 10};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int y = 0; y < FILL_N; y++)
        begin
            for (int x = 0; x < FILL_N; x++)
            begin
                t = '0;
                t.kind = KIND_WR_SRC;
                t.tx = 6'(x);
                t.ty = 6'(y);
                t.color = $urandom;
                send(t, 1'b0, '0);
                t.kind = KIND_WR_DST;
                t.color = $urandom;
                send(t, 1'b0, '0);
            end
        end
        drain();
        write_reg(CFG_DST_W, FILL_N + 1);
        write_reg(CFG_DST_H, FILL_N + 1);
        write_reg(CFG_SRC_W, FILL_N);
        write_reg(CFG_SRC_H, FILL_N);
        write_reg(CFG_SRC_EN, 1);
        cfg_valid <= 1'b0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;

        rows.push_back(row(KIND_WR_DST, 0,0,0,0, 0,0,0,0, 32'hFFFF_FFFF, 63, 63,
                           1, 0, 0, 0));
        rows.push_back(row(KIND_READ, 0,0,0,0, 0,0,0,0, 0, 63, 63, 1, 32'hFFFF_FFFF, 0, 0));
        rows.push_back(row(KIND_WR_DST, 0,0,0,0, 0,0,0,0, 32'h0, 0, 0, 1, 0, 0, 0));
        rows.push_back(row(KIND_READ, 0,0,0,0, 0,0,0,0, 0, 0, 0, 1, 32'h0, 0, 0));
        rows.push_back(row(KIND_WR_SRC, 0,0,0,0, 0,0,0,0, 32'h8040_C020, 0, 0, 1, 0, 0, 0));
        rows.push_back(row(KIND_DRAW, -32768,0,-32768,16384, 0,0,0,0, 32'hFFFF_FFFF, 0, 0,
                           1, 0, 0, 1));
        rows.push_back(row(KIND_DRAW, 32767,0,32767,16384, 0,0,0,0, 32'hFFFF_FFFF, 0, 0,
                           1, 0, 0, 1));
        rows.push_back(row(KIND_DRAW, 0,-32768,16384,-32768, 0,0,0,0, 32'h0, 0, 0,
                           1, 0, 0, 1));
        rows.push_back(row(KIND_DRAW, 0,32767,16384,32767, 0,0,0,0, 32'h0, 0, 0,
                           1, 0, 0, 1));
        rows.push_back(row(KIND_DRAW, 8192,8192,8192,8192, 0,0,0,0, 32'h1234_5678, 0, 0,
                           1, 0, 0, 0));
        rows.push_back(row(KIND_DRAW, 0,0,16384,16384, 0,0,16384,16384, 32'h80FF_FFFF, 0, 0,
                           1, 0, FILL_N * FILL_N, 0));
        rows.push_back(row(KIND_DRAW, -32768,-32768,32767,32767, 0,0,0,0, 32'hFF00_FF00,
                           0, 0, 1, 0, FILL_N * FILL_N, 0));
        rows.push_back(row(KIND_READ, 0,0,0,0, 0,0,0,0, 0, 2, 4, 0, 0, 0, 0));
        rows.push_back(row(KIND_READ, 0,0,0,0, 0,0,0,0, 0, 63, 63, 0, 0, 0, 0));
        rows.push_back(row(KIND_DRAW, 16384,4000,100,16000, -32768,32767,20000,-9000,
                           32'hFF80_40FF, 0, 0, 0, 0, 0, 0));
        foreach (rows[i])
            send(rows[i].txn, rows[i].typed, rows[i].res);

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_reg(CFG_DST_W, phase_regs[p][0]);
            write_reg(CFG_DST_H, phase_regs[p][1]);
            write_reg(CFG_SRC_W, phase_regs[p][2]);
            write_reg(CFG_SRC_H, phase_regs[p][3]);
            write_reg(CFG_SRC_EN, phase_regs[p][4]);
            cfg_valid <= 1'b0;
            if (p == 5)
            begin
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (p == 2 && i == 5)
                    drain();
                send(rand_txn(), 1'b0, '0);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[textured_rect_blit_alpha_blend] OK");
        else
            $display("[textured_rect_blit_alpha_blend] ERROR");
        $finish;
    end
endmodule

FILE: textured_rect_blit_alpha_blend.f
hw/rtl/trb_pkg.sv
hw/rtl/trb_div.sv
hw/rtl/trb_dpath.sv
hw/rtl/trb_ctrl.sv
hw/rtl/textured_rect_blit_alpha_blend.sv
hw/rtl/trb_checker.sv
tb/sv/tb.sv
